/* rtl/core/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/core/jmss_pkg.sv */
// types, constants and helpers of the jpeg marker segment splitter
`timescale 1ns / 1ps
`default_nettype none

package jmss_pkg;

  typedef enum logic [2:0] {
    PH_MHI,
    PH_MLO,
    PH_LHI,
    PH_LLO,
    PH_PAY,
    PH_SCAN,
    PH_SCANF
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_MHI  = 3'd0,
    ROLE_MLO  = 3'd1,
    ROLE_LHI  = 3'd2,
    ROLE_LLO  = 3'd3,
    ROLE_PAY  = 3'd4,
    ROLE_SCAN = 3'd5
  } role_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_TRUNC = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  localparam logic [15:0] MK_SOI   = 16'hFFD8;
  localparam logic [15:0] MK_EOI   = 16'hFFD9;
  localparam logic [15:0] MK_SOS   = 16'hFFDA;
  localparam logic [15:0] MK_APP1  = 16'hFFE1;
  localparam logic [7:0]  BYTE_FF  = 8'hFF;
  localparam logic [7:0]  BYTE_00  = 8'h00;
  localparam logic [7:0]  RST_MASK = 8'hF8;
  localparam logic [7:0]  RST_BASE = 8'hD0;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [15:0] segment_marker;
    logic [2:0]  role;
    logic        first_of_segment;
    logic        kept;
    logic        exif;
    logic [1:0]  status;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              empty;
  } qstat_t;

  function automatic res_t mk_res(logic [7:0] b, logic [15:0] mk, role_e role,
                                  logic first, logic classify);
    res_t r;
    r                  = '0;
    r.byte_out         = b;
    r.segment_marker   = mk;
    r.role             = role;
    r.first_of_segment = first;
    r.exif             = classify && (mk == MK_APP1);
    r.kept             = classify && (mk != MK_SOI) && (mk != MK_EOI) && (mk != MK_APP1);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/jmss_in_if.sv */
// byte input channel of the splitter
`timescale 1ns / 1ps
`default_nettype none

interface jmss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

/* rtl/core/jmss_out_if.sv */
// tagged byte output channel of the splitter
`timescale 1ns / 1ps
`default_nettype none

interface jmss_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [15:0] segment_marker;
  logic [2:0]  role;
  logic        first_of_segment;
  logic        kept;
  logic        exif;
  logic [1:0]  status;
  logic        last_of_run;

  modport source (output valid, output byte_out, output segment_marker, output role,
                  output first_of_segment, output kept, output exif, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input byte_out, input segment_marker, input role,
                  input first_of_segment, input kept, input exif, input status,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/core/jpeg_marker_segment_splitter.sv */
// top level of the jpeg marker segment splitter
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes a JPEG file one byte per beat and tags each byte with the marker of
// its segment, its role in the segment, keep/exif flags and a sticky status.
// A byte is classified in the cycle it is accepted and its results appear at
// the output in the cycle after, through a four-entry result queue. Input
// accepts one byte per cycle while the output drains; a byte that completes
// a marker or an escaped scan pair gives two result beats, so a run of such
// bytes is paced by the single output port. A marker high byte or a scan FF
// gives no result until its partner arrives or the file ends. Input ready is
// low while fewer than two queue entries are free.
module jpeg_marker_segment_splitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  jmss_in_if.sink           in_i,
  jmss_out_if.source        out_o
);

  logic              accept;
  logic              pop;
  logic [1:0]        push_n;
  jmss_pkg::res_t    res0, res1, head;
  jmss_pkg::qstat_t  q_stat;
  jmss_pkg::status_e status;

  assign in_i.ready = (q_stat.level <= jmss_pkg::QLVL_W'(jmss_pkg::QDEPTH - 2));
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  jmss_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (accept),
    .byte_i   (in_i.data_byte),
    .eof_i    (in_i.end_of_file),
    .push_n_o (push_n),
    .res0_o   (res0),
    .res1_o   (res1),
    .status_o (status)
  );

  jmss_res_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .pop_i    (pop),
    .head_o   (head),
    .stat_o   (q_stat)
  );

  assign out_o.valid            = !q_stat.empty;
  assign out_o.byte_out         = head.byte_out;
  assign out_o.segment_marker   = head.segment_marker;
  assign out_o.role             = head.role;
  assign out_o.first_of_segment = head.first_of_segment;
  assign out_o.kept             = head.kept;
  assign out_o.exif             = head.exif;
  assign out_o.status           = head.status;
  assign out_o.last_of_run      = head.last_of_run;

  // a pushed beat is visible on the output next cycle
  `ASSERT_AT(a_push_visible, (push_n != 2'd0) |=> !q_stat.empty, "push not visible")
  // status never changes once it has left running
  `ASSERT_AT(a_status_sticky, (status != jmss_pkg::ST_RUN) |=> (status == $past(status)), "status not sticky")
  // queue never overfills
  `ASSERT_NEVER(a_queue_ovf, q_stat.level > jmss_pkg::QLVL_W'(jmss_pkg::QDEPTH), "queue overflow")

endmodule

`default_nettype wire

/* rtl/core/jmss_parser.sv */
// segment phase tracker: classifies one byte per beat into up to two results
`timescale 1ns / 1ps
`default_nettype none

module jmss_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  input  logic              eof_i,
  output logic [1:0]        push_n_o,
  output jmss_pkg::res_t    res0_o,
  output jmss_pkg::res_t    res1_o,
  output jmss_pkg::status_e status_o
);

  jmss_pkg::phase_e  phase_q, phase_d;
  jmss_pkg::status_e status_q, status_d;
  logic [7:0]        held_q, held_d;
  logic [15:0]       marker_q, marker_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [15:0]       remain_q, remain_d;

  logic              start;
  logic [7:0]        start_hi;
  logic [15:0]       start_mk;
  logic [15:0]       len;
  logic [15:0]       remain_dec;
  logic [1:0]        n;
  jmss_pkg::res_t    r0, r1;

  assign len        = {len_hi_q, byte_i};
  assign remain_dec = remain_q - 16'd1;

  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    held_d   = held_q;
    marker_d = marker_q;
    len_hi_d = len_hi_q;
    remain_d = remain_q;
    start    = 1'b0;
    start_hi = held_q;
    start_mk = {held_q, byte_i};
    n        = 2'd0;
    r0       = '0;
    r1       = '0;

    if (status_q != jmss_pkg::ST_RUN) begin
      r0 = jmss_pkg::mk_res(byte_i, 16'h0000, jmss_pkg::ROLE_PAY, 1'b0, 1'b0);
      n  = 2'd1;
    end else begin
      unique case (phase_q)
        jmss_pkg::PH_MHI: begin
          held_d  = byte_i;
          phase_d = jmss_pkg::PH_MLO;
        end
        jmss_pkg::PH_MLO: begin
          start    = 1'b1;
          start_hi = held_q;
        end
        jmss_pkg::PH_LHI: begin
          r0       = jmss_pkg::mk_res(byte_i, marker_q, jmss_pkg::ROLE_LHI, 1'b0, 1'b1);
          n        = 2'd1;
          len_hi_d = byte_i;
          phase_d  = jmss_pkg::PH_LLO;
        end
        jmss_pkg::PH_LLO: begin
          r0 = jmss_pkg::mk_res(byte_i, marker_q, jmss_pkg::ROLE_LLO, 1'b0, 1'b1);
          n  = 2'd1;
          if (len < 16'd2) begin
            status_d = jmss_pkg::ST_SHORT;
          end else begin
            remain_d = len - 16'd2;
            phase_d  = (len != 16'd2) ? jmss_pkg::PH_PAY : jmss_pkg::PH_MHI;
          end
        end
        jmss_pkg::PH_PAY: begin
          r0       = jmss_pkg::mk_res(byte_i, marker_q, jmss_pkg::ROLE_PAY, 1'b0, 1'b1);
          n        = 2'd1;
          remain_d = remain_dec;
          if (remain_dec == 16'd0) begin
            phase_d = jmss_pkg::PH_MHI;
          end
        end
        jmss_pkg::PH_SCAN: begin
          if (byte_i == jmss_pkg::BYTE_FF) begin
            held_d  = jmss_pkg::BYTE_FF;
            phase_d = jmss_pkg::PH_SCANF;
          end else begin
            r0 = jmss_pkg::mk_res(byte_i, marker_q, jmss_pkg::ROLE_SCAN, 1'b0, 1'b1);
            n  = 2'd1;
          end
        end
        jmss_pkg::PH_SCANF: begin
          if (byte_i == jmss_pkg::BYTE_00 ||
              (byte_i & jmss_pkg::RST_MASK) == jmss_pkg::RST_BASE) begin
            r0 = jmss_pkg::mk_res(jmss_pkg::BYTE_FF, marker_q, jmss_pkg::ROLE_SCAN,
                                  1'b0, 1'b1);
            r1 = jmss_pkg::mk_res(byte_i, marker_q, jmss_pkg::ROLE_SCAN, 1'b0, 1'b1);
            n  = 2'd2;
            phase_d = jmss_pkg::PH_SCAN;
          end else begin
            start    = 1'b1;
            start_hi = jmss_pkg::BYTE_FF;
          end
        end
        default: begin
          phase_d = jmss_pkg::PH_MHI;
        end
      endcase

      if (start) begin
        start_mk = {start_hi, byte_i};
        marker_d = start_mk;
        r0 = jmss_pkg::mk_res(start_hi, start_mk, jmss_pkg::ROLE_MHI, 1'b1, 1'b1);
        r1 = jmss_pkg::mk_res(byte_i, start_mk, jmss_pkg::ROLE_MLO, 1'b0, 1'b1);
        n  = 2'd2;
        if (start_mk == jmss_pkg::MK_SOI) begin
          phase_d = jmss_pkg::PH_MHI;
        end else if (start_mk == jmss_pkg::MK_EOI) begin
          status_d = jmss_pkg::ST_DONE;
        end else if (start_mk == jmss_pkg::MK_SOS) begin
          phase_d = jmss_pkg::PH_SCAN;
        end else begin
          phase_d = jmss_pkg::PH_LHI;
        end
      end

      // file ends early: flush a held byte, if any
      if (status_d == jmss_pkg::ST_RUN && eof_i) begin
        status_d = jmss_pkg::ST_TRUNC;
        if (n == 2'd0) begin
          if (phase_d == jmss_pkg::PH_MLO) begin
            r0 = jmss_pkg::mk_res(held_d, {held_d, 8'h00}, jmss_pkg::ROLE_MHI, 1'b1, 1'b0);
          end else begin
            r0 = jmss_pkg::mk_res(held_d, marker_q, jmss_pkg::ROLE_SCAN, 1'b0, 1'b1);
          end
          n = 2'd1;
        end
      end
    end

    r0.status      = status_d;
    r1.status      = status_d;
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= jmss_pkg::PH_MHI;
      status_q <= jmss_pkg::ST_RUN;
      held_q   <= '0;
      marker_q <= '0;
      len_hi_q <= '0;
      remain_q <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      status_q <= status_d;
      held_q   <= held_d;
      marker_q <= marker_d;
      len_hi_q <= len_hi_d;
      remain_q <= remain_d;
    end
  end

  assign push_n_o = take_i ? n : 2'd0;
  assign res0_o   = r0;
  assign res1_o   = r1;
  assign status_o = status_q;

endmodule

`default_nettype wire

/* rtl/core/jmss_res_queue.sv */
// result queue: takes up to two results per beat, hands out one per beat
`timescale 1ns / 1ps
`default_nettype none

module jmss_res_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  jmss_pkg::res_t   res0_i,
  input  jmss_pkg::res_t   res1_i,
  input  logic             pop_i,
  output jmss_pkg::res_t   head_o,
  output jmss_pkg::qstat_t stat_o
);

  jmss_pkg::res_t                  mem_q [jmss_pkg::QDEPTH];
  logic [jmss_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [jmss_pkg::QPTR_W-1:0]     wr_ptr_nx;
  logic [jmss_pkg::QLVL_W-1:0]     level_q, level_d;

  assign wr_ptr_nx = wr_ptr_q + jmss_pkg::QPTR_W'(1);
  assign level_d   = level_q + jmss_pkg::QLVL_W'(push_n_i)
                     - jmss_pkg::QLVL_W'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + jmss_pkg::QPTR_W'(push_n_i);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + jmss_pkg::QPTR_W'(1);
      end
      level_q <= level_d;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.empty = (level_q == '0);

endmodule

`default_nettype wire

/* tb/sv/jmss_tag_checker.sv */
// checker that predicts the tagged output beats of the splitter and compares them
`timescale 1ns / 1ps

module jmss_tag_checker
  import jmss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  jmss_in_if   byte_ch_i,
  jmss_out_if  tag_ch_i,
  output int   fail_count_o,
  output int   open_beats_o
);

  phase_e      seg_phase;
  logic [7:0]  held_byte;
  logic [15:0] seg_marker;
  logic [7:0]  len_msb;
  logic [15:0] pay_left;
  status_e     run_status;

  res_t        due_tags[$];
  res_t        step_tags[$];
  res_t        want;
  int          fail_n;

  function automatic res_t tag_byte(logic [7:0] b, logic [15:0] mk, role_e r, logic first,
                                    logic sorted);
    res_t t;
    t                  = '0;
    t.byte_out         = b;
    t.segment_marker   = mk;
    t.role             = r;
    t.first_of_segment = first;
    if (sorted) begin
      t.exif = (mk == MK_APP1);
      t.kept = (mk != MK_SOI) && (mk != MK_EOI) && (mk != MK_APP1);
    end
    return t;
  endfunction

  task automatic open_segment(logic [7:0] hi, logic [7:0] lo);
    seg_marker = {hi, lo};
    step_tags.push_back(tag_byte(hi, seg_marker, ROLE_MHI, 1'b1, 1'b1));
    step_tags.push_back(tag_byte(lo, seg_marker, ROLE_MLO, 1'b0, 1'b1));
    if (seg_marker == MK_SOI) begin
      seg_phase = PH_MHI;
    end else if (seg_marker == MK_EOI) begin
      run_status = ST_DONE;
    end else if (seg_marker == MK_SOS) begin
      seg_phase = PH_SCAN;
    end else begin
      seg_phase = PH_LHI;
    end
  endtask

  task automatic classify_byte(logic [7:0] b, logic eof);
    logic [15:0] seg_len;
    step_tags.delete();
    if (run_status != ST_RUN) begin
      step_tags.push_back(tag_byte(b, 16'h0000, ROLE_PAY, 1'b0, 1'b0));
    end else begin
      case (seg_phase)
        PH_MHI: begin
          held_byte = b;
          seg_phase = PH_MLO;
        end
        PH_MLO: open_segment(held_byte, b);
        PH_LHI: begin
          step_tags.push_back(tag_byte(b, seg_marker, ROLE_LHI, 1'b0, 1'b1));
          len_msb   = b;
          seg_phase = PH_LLO;
        end
        PH_LLO: begin
          seg_len = {len_msb, b};
          step_tags.push_back(tag_byte(b, seg_marker, ROLE_LLO, 1'b0, 1'b1));
          if (seg_len < 16'd2) begin
            run_status = ST_SHORT;
          end else begin
            pay_left  = seg_len - 16'd2;
            seg_phase = (pay_left != 16'd0) ? PH_PAY : PH_MHI;
          end
        end
        PH_PAY: begin
          step_tags.push_back(tag_byte(b, seg_marker, ROLE_PAY, 1'b0, 1'b1));
          pay_left = pay_left - 16'd1;
          if (pay_left == 16'd0) seg_phase = PH_MHI;
        end
        PH_SCAN: begin
          if (b == BYTE_FF) begin
            held_byte = BYTE_FF;
            seg_phase = PH_SCANF;
          end else begin
            step_tags.push_back(tag_byte(b, seg_marker, ROLE_SCAN, 1'b0, 1'b1));
          end
        end
        default: begin
          if (b == BYTE_00 || (b & RST_MASK) == RST_BASE) begin
            step_tags.push_back(tag_byte(BYTE_FF, seg_marker, ROLE_SCAN, 1'b0, 1'b1));
            step_tags.push_back(tag_byte(b, seg_marker, ROLE_SCAN, 1'b0, 1'b1));
            seg_phase = PH_SCAN;
          end else begin
            open_segment(BYTE_FF, b);
          end
        end
      endcase
      if (run_status == ST_RUN && eof) begin
        run_status = ST_TRUNC;
        if (step_tags.size() == 0) begin
          if (seg_phase == PH_MLO) begin
            step_tags.push_back(tag_byte(held_byte, {held_byte, 8'h00}, ROLE_MHI, 1'b1, 1'b0));
          end else begin
            step_tags.push_back(tag_byte(held_byte, seg_marker, ROLE_SCAN, 1'b0, 1'b1));
          end
        end
      end
    end
    foreach (step_tags[k]) begin
      step_tags[k].status      = run_status;
      step_tags[k].last_of_run = (k == step_tags.size() - 1);
      due_tags.push_back(step_tags[k]);
    end
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_n++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_phase  = PH_MHI;
      held_byte  = '0;
      seg_marker = '0;
      len_msb    = '0;
      pay_left   = '0;
      run_status = ST_RUN;
      fail_n     = 0;
      due_tags.delete();
      fail_count_o <= 0;
      open_beats_o <= 0;
    end else begin
      if (tag_ch_i.valid && tag_ch_i.ready) begin
        if (due_tags.size() == 0) begin
          $error("output beat with nothing due: byte_out 0x%0h", tag_ch_i.byte_out);
          fail_n++;
        end else begin
          want = due_tags.pop_front();
          check_field("byte_out", want.byte_out, tag_ch_i.byte_out);
          check_field("segment_marker", want.segment_marker, tag_ch_i.segment_marker);
          check_field("role", want.role, tag_ch_i.role);
          check_field("first_of_segment", want.first_of_segment, tag_ch_i.first_of_segment);
          check_field("kept", want.kept, tag_ch_i.kept);
          check_field("exif", want.exif, tag_ch_i.exif);
          check_field("status", want.status, tag_ch_i.status);
          check_field("last_of_run", want.last_of_run, tag_ch_i.last_of_run);
        end
      end
      if (byte_ch_i.valid && byte_ch_i.ready) begin
        classify_byte(byte_ch_i.data_byte, byte_ch_i.end_of_file);
      end
      fail_count_o <= fail_n;
      open_beats_o <= due_tags.size();
    end
  end

endmodule

/* tb/sv/jpeg_marker_segment_splitter_tb.sv */
// testbench top: builds a jpeg byte stream, drives it with random gaps and gives the verdict
`timescale 1ns / 1ps

module jpeg_marker_segment_splitter_tb;
  import jmss_pkg::*;

  typedef enum int {
    WRAP_EOI,
    WRAP_EOI_AT_EOF,
    WRAP_SHORT,
    WRAP_SHORT_AT_EOF,
    WRAP_CUT
  } wrap_e;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 650;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   open_beats;
  int   cycle_n = 0;

  logic [7:0] file_b[$];
  logic       eof_q[$];
  int         opening_len;
  logic       scan_open;
  logic       src_calm;

  jmss_in_if  byte_ch ();
  jmss_out_if tag_ch ();

  jpeg_marker_segment_splitter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (tag_ch)
  );

  jmss_tag_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_ch_i    (byte_ch),
    .tag_ch_i     (tag_ch),
    .fail_count_o (fail_count),
    .open_beats_o (open_beats)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("FAIL jpeg_marker_segment_splitter");
      $finish;
    end
  end

  task automatic add(logic [7:0] b);
    file_b.push_back(b);
    eof_q.push_back(1'b0);
  endtask

  task automatic add_segment();
    int          pick;
    int          n;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  b;
    logic [15:0] seg_len;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      add(MK_SOS[15:8]);
      add(MK_SOS[7:0]);
      n = $urandom_range(0, 40);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        add(b);
        if (b == BYTE_FF) begin
          if ($urandom_range(0, 1)) add(BYTE_00);
          else add(RST_BASE | 8'($urandom_range(0, 7)));
        end
      end
      scan_open = 1'b1;
    end else if (pick == 2) begin
      add(MK_SOI[15:8]);
      add(MK_SOI[7:0]);
      scan_open = 1'b0;
    end else begin
      hi = (pick == 3 && !scan_open) ? 8'($urandom_range(0, 255)) : BYTE_FF;
      do begin
        lo = 8'($urandom_range(0, 255));
      end while (hi == BYTE_FF && (lo == MK_EOI[7:0] || lo == MK_SOS[7:0] || lo == MK_SOI[7:0] ||
                 (scan_open && (lo == BYTE_00 || (lo & RST_MASK) == RST_BASE))));
      n = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
      seg_len = 16'(n + 2);
      add(hi);
      add(lo);
      add(seg_len[15:8]);
      add(seg_len[7:0]);
      repeat (n) add(8'($urandom_range(0, 255)));
      scan_open = 1'b0;
    end
  endtask

  task automatic build_file();
    wrap_e wrap;
    int    cut;
    add(MK_SOI[15:8]); add(MK_SOI[7:0]);
    add(8'h00); add(8'h00); add(8'h00); add(8'h02);
    add(MK_APP1[15:8]); add(MK_APP1[7:0]); add(8'h00); add(8'h03); add(BYTE_FF);
    add(MK_SOS[15:8]); add(MK_SOS[7:0]); add(BYTE_00);
    add(BYTE_FF); add(BYTE_00); add(BYTE_FF); add(RST_BASE | 8'h07);
    add(BYTE_FF); add(RST_BASE); add(8'h12);
    add(BYTE_FF); add(BYTE_FF); add(8'h00); add(8'h02);
    opening_len = file_b.size();
    scan_open   = 1'b0;
    while (file_b.size() < opening_len + RANDOM_BYTES) add_segment();
    wrap = wrap_e'($urandom_range(WRAP_EOI, WRAP_CUT));
    case (wrap)
      WRAP_EOI, WRAP_EOI_AT_EOF: begin
        add(MK_EOI[15:8]);
        add(MK_EOI[7:0]);
        if (wrap == WRAP_EOI_AT_EOF) eof_q[eof_q.size() - 1] = 1'b1;
      end
      WRAP_SHORT, WRAP_SHORT_AT_EOF: begin
        add(BYTE_FF);
        add(8'hC0);
        add(8'h00);
        add(8'($urandom_range(0, 1)));
        if (wrap == WRAP_SHORT_AT_EOF) eof_q[eof_q.size() - 1] = 1'b1;
      end
      default: begin
        cut = $urandom_range(opening_len, file_b.size() - 1);
        if ($urandom_range(0, 1)) begin
          while (cut < file_b.size() - 1 && file_b[cut] != BYTE_FF) cut++;
        end
        eof_q[cut] = 1'b1;
      end
    endcase
    repeat (4) begin
      add(8'($urandom_range(0, 255)));
      eof_q[eof_q.size() - 1] = 1'($urandom_range(0, 1));
    end
    add(8'($urandom_range(0, 255)));
    eof_q[eof_q.size() - 1] = 1'b1;
  endtask

  task automatic send_byte(logic [7:0] b, logic eof);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.end_of_file <= eof;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (open_beats != 0) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    int beat_n;
    logic sink_calm;
    beat_n    = 0;
    sink_calm = 1'b0;
    tag_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (beat_n % 64 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      beat_n++;
      stall = sink_calm ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        tag_ch.ready <= 1'b0;
        @(posedge clk_i);
      end
      tag_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!tag_ch.valid);
    end
  end

  initial begin
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= '0;
    byte_ch.end_of_file <= 1'b0;
    src_calm = 1'b0;
    build_file();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < file_b.size(); i++) begin
      if (i % 64 == 0) src_calm = ($urandom_range(0, 3) == 0);
      if (i == opening_len || $urandom_range(0, 79) == 0) wait_drained();
      send_byte(file_b[i], eof_q[i]);
    end
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && open_beats == 0) begin
      $display("PASS jpeg_marker_segment_splitter");
    end else begin
      $display("FAIL jpeg_marker_segment_splitter");
    end
    $finish;
  end

endmodule
